>>> hw/rtl/fpa_pkg.sv
// Shared types, constants and command codes for the Q24.8 fixed-point ALU.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // Dividend width of the divider: |a| shifted left by the fraction bits.
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    // Width of a product magnitude after the fraction bits are dropped.
    localparam int MAG_W     = 2 * DATA_W - FRAC_BITS;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_CMP      = 4'd6,
        CMD_INC      = 4'd7,
        CMD_DEC      = 4'd8,
        CMD_FROM_INT = 4'd9,
        CMD_TO_INT   = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // Which unit of the back end produces the result.
    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0]               command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     is_less;
        logic                     is_equal;
        logic                     is_greater;
        status_t                  status;
    } out_word_t;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        kind_t             kind;
        logic              neg;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        out_word_t         simple;
    } fe_word_t;

    // Word carried through the back-end pipeline stages.
    typedef struct packed {
        kind_t             kind;
        logic              neg;
        logic [DATA_W-1:0] rem;
        logic [DIV_W-1:0]  dq;
        logic [DATA_W-1:0] den;
        out_word_t         res;
    } bk_word_t;

endpackage

>>> hw/rtl/fpa_front.sv
// Front end: accepts request words, decodes the command and computes the
// operations that need no multiplier or divider. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_front
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  in_word_t req_word,
    output logic     push_valid,
    output fe_word_t push_word,
    input  logic     push_room
);

    logic     fe_vld_reg;
    logic     fe_vld_next;
    fe_word_t fe_word_reg;
    fe_word_t fe_word_next;
    logic     take;

    // Hold the front register while the queue is full.
    assign req_stall   = fe_vld_reg && !push_room;
    assign take        = req_valid && !req_stall;
    assign fe_vld_next = take || (fe_vld_reg && !push_room);
    assign push_valid  = fe_vld_reg;
    assign push_word   = fe_word_reg;

    // Decode and work out everything that needs no multiplier or divider.
    always_comb
    begin
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [DATA_W:0]          wide;
        logic                     a_gt_b;
        logic [FRAC_BITS:0]       top;
        a      = req_word.operand_a;
        b      = req_word.operand_b;
        a_gt_b = a > b;
        wide   = '0;
        top    = a[DATA_W-1:DATA_W-1-FRAC_BITS];
        fe_word_next        = '0;
        fe_word_next.kind   = KIND_SIMPLE;
        fe_word_next.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        fe_word_next.mag_a  = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        fe_word_next.mag_b  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        fe_word_next.simple.status = ST_OK;
        case (req_word.command)
            CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC:
            begin
                case (req_word.command)
                    CMD_ADD: wide = {a[DATA_W-1], a} + {b[DATA_W-1], b};
                    CMD_SUB: wide = {a[DATA_W-1], a} - {b[DATA_W-1], b};
                    CMD_INC: wide = {a[DATA_W-1], a} + (DATA_W+1)'(1);
                    default: wide = {a[DATA_W-1], a} - (DATA_W+1)'(1);
                endcase
                fe_word_next.simple.result = wide[DATA_W-1:0];
                fe_word_next.simple.status =
                    (wide[DATA_W] != wide[DATA_W-1]) ? ST_OVF : ST_OK;
            end
            CMD_MUL:
            begin
                fe_word_next.kind = KIND_MUL;
            end
            CMD_DIV:
            begin
                if (b == '0)
                begin
                    fe_word_next.simple.status = ST_DIV0;
                end
                else
                begin
                    fe_word_next.kind = KIND_DIV;
                end
            end
            CMD_MIN:
            begin
                fe_word_next.simple.result = a_gt_b ? b : a;
            end
            CMD_MAX:
            begin
                fe_word_next.simple.result = a_gt_b ? a : b;
            end
            CMD_CMP:
            begin
                fe_word_next.simple.is_less    = a < b;
                fe_word_next.simple.is_equal   = a == b;
                fe_word_next.simple.is_greater = a_gt_b;
            end
            CMD_FROM_INT:
            begin
                // The product fits only when the dropped top bits copy the sign.
                fe_word_next.simple.result = a <<< FRAC_BITS;
                fe_word_next.simple.status =
                    ((top == '0) || (top == '1)) ? ST_OK : ST_OVF;
            end
            CMD_TO_INT:
            begin
                fe_word_next.simple.result = a >>> FRAC_BITS;
            end
            default:
            begin
                fe_word_next.simple = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_vld_reg <= 1'b0;
        end
        else
        begin
            fe_vld_reg <= fe_vld_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fe_word_reg <= fe_word_next;
        end
    end

endmodule

>>> hw/rtl/fpa_queue.sv
// Short queue between the front end and the back end.
// Depends on fpa_pkg for the word type and depth.
`timescale 1ns / 1ps

module fpa_queue
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  fe_word_t push_word,
    output logic     push_room,
    input  logic     pop,
    output logic     head_valid,
    output fe_word_t head_word
);

    fe_word_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] wptr_next;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W-1:0] rptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push_en;
    logic              pop_en;

    assign push_room  = count_reg < (QPTR_W+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_word  = mem_reg[rptr_reg];
    assign push_en    = push_valid && push_room;
    assign pop_en     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push_en)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wptr_reg] <= push_word;
        end
    end

endmodule

>>> hw/rtl/fpa_back.sv
// Back end: pipelined multiplier and one-bit-per-stage restoring divider,
// with an output register toward the receiver. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_back
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  fe_word_t  head_word,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    bk_word_t              stg_reg  [DIV_W];
    bk_word_t              stg_next [DIV_W];
    logic [DIV_W-1:0]      stg_vld_reg;
    logic [2*DATA_W-1:0]   prod_reg;
    logic [2*DATA_W-1:0]   prod_next;
    logic                  out_vld_reg;
    out_word_t             out_word_reg;
    out_word_t             out_word_next;
    logic                  advance;
    bk_word_t              init;

    // One restoring division step: bring in one dividend bit, emit one quotient bit.
    function automatic bk_word_t div_step(bk_word_t w);
        logic [DATA_W:0] r;
        logic            qb;
        bk_word_t        o;
        o  = w;
        r  = {w.rem, w.dq[DIV_W-1]};
        qb = r >= {1'b0, w.den};
        if (qb)
        begin
            r = r - {1'b0, w.den};
        end
        o.rem = r[DATA_W-1:0];
        o.dq  = {w.dq[DIV_W-2:0], qb};
        return o;
    endfunction

    // Apply the sign to a magnitude, wrap it and flag values outside 32 signed bits.
    function automatic out_word_t finish(logic [MAG_W-1:0] m, logic neg);
        out_word_t o;
        logic      ovf;
        o   = '0;
        ovf = (|m[MAG_W-1:DATA_W]) ||
              (m[DATA_W-1] && !(neg && (m[DATA_W-2:0] == '0)));
        o.result = neg ? -m[DATA_W-1:0] : m[DATA_W-1:0];
        o.status = ovf ? ST_OVF : ST_OK;
        return o;
    endfunction

    // The whole pipeline moves unless a finished word waits on a stalled receiver.
    assign advance   = !out_vld_reg || !rsp_stall;
    assign pop       = advance;
    assign rsp_valid = out_vld_reg;
    assign rsp_word  = out_word_reg;

    // Stage zero loads the divider and starts the multiply.
    always_comb
    begin
        init       = '0;
        init.kind  = head_word.kind;
        init.neg   = head_word.neg;
        init.dq    = {head_word.mag_a, {FRAC_BITS{1'b0}}};
        init.den   = head_word.mag_b;
        init.res   = head_word.simple;
        stg_next[0] = div_step(init);
        prod_next   = head_word.mag_a * head_word.mag_b;
    end

    // Stage one also finishes the multiply; later stages only divide.
    genvar k;
    generate
        for (k = 1; k < DIV_W; k++)
        begin : g_stage
            always_comb
            begin
                stg_next[k] = div_step(stg_reg[k-1]);
                if ((k == 1) && (stg_reg[k-1].kind == KIND_MUL))
                begin
                    stg_next[k].res = finish(prod_reg[2*DATA_W-1:FRAC_BITS],
                                             stg_reg[k-1].neg);
                end
            end
        end
    endgenerate

    // Output selection: the divider quotient or the word carried along.
    always_comb
    begin
        if (stg_reg[DIV_W-1].kind == KIND_DIV)
        begin
            out_word_next = finish(MAG_W'(stg_reg[DIV_W-1].dq), stg_reg[DIV_W-1].neg);
        end
        else
        begin
            out_word_next = stg_reg[DIV_W-1].res;
        end
    end

    // Valid bits of the stages and of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            stg_vld_reg <= {stg_vld_reg[DIV_W-2:0], head_valid};
            out_vld_reg <= stg_vld_reg[DIV_W-1];
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
            prod_reg     <= prod_next;
            out_word_reg <= out_word_next;
        end
    end

endmodule

>>> hw/rtl/fixed_point_q24_8_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Connects fpa_front, fpa_queue and fpa_back; depends on fpa_pkg.
//
// Usage:
// - Request channel (req_valid, req_stall, req_word): one word carries a
//   command and two raw 32-bit operands. A word is taken at a clock edge
//   where req_valid is high and req_stall is low.
// - Response channel (rsp_valid, rsp_stall, rsp_word): exactly one word per
//   request, in request order, holding the result, compare flags and status.
// - Throughput is one word per cycle when nothing stalls. From acceptance
//   a word passes the front register, one queue slot, 40 divider stages
//   (32 operand bits plus 8 fraction bits, one quotient bit per stage)
//   and the output register. Every command takes this path.
// - When rsp_stall is high while a word waits in the output register, the
//   back-end pipeline freezes; the two-entry queue then fills, and after
//   that req_stall rises.
// - Reset clears all valid bits and the queue; no word is in flight after
//   reset.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_word_t  req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    logic     push_valid;
    logic     push_room;
    fe_word_t push_word;
    logic     head_valid;
    fe_word_t head_word;
    logic     pop;

    fpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_room  (push_room)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_room  (push_room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    fpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

endmodule
